@@ design/dni_pkg.sv @@
// shared constants and types for the dma network interface
// no dependencies
package dni_pkg;
   localparam int BufDepthDefault = 16;
   localparam int ArbTimeoutDefault = 16;
   localparam int WORD_BYTES = 4;
   localparam logic [3:0] BE_FULL = 4'hF;

   localparam logic [2:0] CSR_BASE_ADDR = 3'd0;
   localparam logic [2:0] CSR_SECOND_ADDR = 3'd1;
   localparam logic [2:0] CSR_WORD_COUNT = 3'd2;
   localparam logic [2:0] CSR_SECOND_COUNT = 3'd3;
   localparam logic [2:0] CSR_DIRECTION = 3'd4;

   typedef struct packed {
      logic        start_pulse;
      logic        rx_valid;
      logic [31:0] rx_word;
      logic        tx_credit;
      logic [31:0] mem_read_word;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [31:0] tx_word;
      logic        rx_credit;
      logic [31:0] mem_addr;
      logic [3:0]  mem_byte_enable;
      logic [31:0] mem_write_word;
      logic        irq;
      logic        send_busy;
      logic        recv_busy;
   } rsp_type;
endpackage

@@ design/dni_ram.sv @@
// generic single-port-write, one-read ram with registered read data
// no dependencies
module dni_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ design/dma_network_interface.sv @@
// dma with network interface: receive buffer, parser, two dmas, arbiter
// depends on dni_pkg and dni_ram
//
// One transfer on req_ is one clock of the pins and yields exactly one transfer on rsp_.
// A new item is taken every cycle while the result register is free or being drained,
// so the sustained rate is one item per clock. The flit buffer sits in a ram with a
// registered read; the entry at the read pointer is prefetched each cycle, and a flit
// written to that same entry in the current item is forwarded. Header tags are kept
// in flip-flops cleared by reset, so no clearing pass is needed.
module dma_network_interface #(
   parameter int BUF_DEPTH = dni_pkg::BufDepthDefault,
   parameter int ARB_TIMEOUT = dni_pkg::ArbTimeoutDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_pulse, rx_valid, rx_word, tx_credit, mem_read_word, zero fill
   input  logic [71:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tx_valid, tx_word, rx_credit, mem_addr, mem_byte_enable, mem_write_word,
   // irq, send_busy, recv_busy, zero fill
   output logic [111:0]          rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import dni_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [15:0] TIMEOUT = 16'(ARB_TIMEOUT);
   localparam logic [AW-1:0] LAST_PTR = AW'(BUF_DEPTH - 1);

   typedef enum logic [1:0] {ARB_ROUND, ARB_SEND, ARB_RECV} arb_type;
   typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DATA} phase_type;
   typedef enum logic [1:0] {RV_WAIT, RV_COPY, RV_END} recv_type;
   typedef enum logic [1:0] {SD_WAIT, SD_LOAD, SD_COPY, SD_END} send_type;

   req_type req;
   assign req.start_pulse   = req_tdata[0];
   assign req.rx_valid      = req_tdata[1];
   assign req.rx_word       = req_tdata[33:2];
   assign req.tx_credit     = req_tdata[34];
   assign req.mem_read_word = req_tdata[66:35];

   logic [31:0] base_ff, second_ff, count_ff, second_count_ff;
   logic        dir_ff;
   arb_type arb_ff, arb_in;
   logic pri_ff, pri_in, wg_ff, wg_in, rg_ff, rg_in;
   logic [15:0] tim_ff, tim_in;
   logic [BUF_DEPTH-1:0] tag_ff, tag_in;
   logic [AW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic add_ff, add_in;
   phase_type ph_ff, ph_in;
   logic [31:0] left_ff, left_in;
   recv_type rv_ff, rv_in;
   logic [31:0] raddr_ff, raddr_in, rrem_ff, rrem_in;
   logic [3:0] hc_ff, hc_in;
   send_type sd_ff, sd_in;
   logic [31:0] saddr_ff, saddr_in, saddr2_ff, saddr2_in, srem_ff, srem_in, srem2_ff, srem2_in;
   logic txv_ff, txv_in;
   logic [31:0] txw_ff, txw_in, wd_ff, wd_in;
   logic [3:0] be_ff, be_in;
   logic rsp_valid_ff;
   logic [111:0] rsp_data_ff;

   logic fire;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // head entry prefetch with forwarding of a same-entry write
   logic wr_en;
   logic [31:0] ram_q, fwd_word, head_word;
   logic fwd_ff;
   assign wr_en = fire && req.rx_valid && !(rp_ff == wp_ff && add_ff);
   dni_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_flit_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(req.rx_word),
      .rd_addr(fire ? rp_in : rp_ff),
      .rd_data(ram_q)
   );
   always_ff @(posedge clock) begin
      fwd_ff <= wr_en && (wp_ff == (fire ? rp_in : rp_ff));
      fwd_word <= req.rx_word;
   end
   assign head_word = fwd_ff ? fwd_word : ram_q;

   always_comb begin
      logic same, rav, recv_act, send_act;
      same = rp_ff == wp_ff;
      rav = !(same && !add_ff);
      recv_act = rv_ff != RV_WAIT;
      send_act = sd_ff != SD_WAIT;
      arb_in = arb_ff; pri_in = pri_ff; tim_in = tim_ff; wg_in = wg_ff; rg_in = rg_ff;
      tag_in = tag_ff; rp_in = rp_ff; wp_in = wp_ff; add_in = add_ff; ph_in = ph_ff;
      left_in = left_ff; rv_in = rv_ff; raddr_in = raddr_ff; rrem_in = rrem_ff;
      hc_in = hc_ff; sd_in = sd_ff; saddr_in = saddr_ff; saddr2_in = saddr2_ff;
      srem_in = srem_ff; srem2_in = srem2_ff; txv_in = txv_ff; txw_in = txw_ff;
      wd_in = wd_ff; be_in = be_ff;

      unique case (arb_ff)
         ARB_ROUND: begin
            if (!pri_ff) begin
               if (rv_ff == RV_COPY) begin arb_in = ARB_RECV; wg_in = 1'b1; end
               else if (send_act) begin arb_in = ARB_SEND; rg_in = 1'b1; end
            end else begin
               if (send_act) begin arb_in = ARB_SEND; rg_in = 1'b1; end
               else if (rv_ff == RV_COPY) begin arb_in = ARB_RECV; wg_in = 1'b1; end
            end
         end
         ARB_SEND: begin
            if (sd_ff == SD_END || (tim_ff >= TIMEOUT && recv_act)) begin
               tim_in = '0; arb_in = ARB_ROUND; rg_in = 1'b0; pri_in = !pri_ff;
            end else if (tim_ff != 16'hFFFF) tim_in = tim_ff + 1'b1;
         end
         ARB_RECV: begin
            if (rv_ff == RV_END || (tim_ff >= TIMEOUT && send_act)) begin
               tim_in = '0; arb_in = ARB_ROUND; wg_in = 1'b0; pri_in = !pri_ff;
            end else if (tim_ff != 16'hFFFF) tim_in = tim_ff + 1'b1;
         end
         default: ;
      endcase

      if (wr_en) begin
         add_in = 1'b1;
         wp_in = next_ptr(wp_ff);
         case (ph_ff)
            PH_HEADER: begin hc_in = hc_ff + 1'b1; tag_in[wp_ff] = 1'b1; ph_in = PH_PAYLOAD; end
            PH_PAYLOAD: begin tag_in[wp_ff] = 1'b0; left_in = req.rx_word - 1'b1; ph_in = PH_DATA; end
            PH_DATA: begin
               tag_in[wp_ff] = 1'b0;
               if (left_ff == '0) ph_in = PH_HEADER;
               else left_in = left_ff - 1'b1;
            end
            default: ;
         endcase
      end

      unique case (rv_ff)
         RV_WAIT: begin
            if (req.start_pulse && dir_ff) begin
               raddr_in = base_ff - 32'(WORD_BYTES);
               rrem_in = count_ff - 1'b1;
               if (tag_in[rp_ff] && hc_in != '0) hc_in = hc_in - 1'b1;
               rv_in = RV_COPY;
            end
         end
         RV_COPY: begin
            if (wg_ff && rav) begin
               be_in = BE_FULL; wd_in = head_word;
               rp_in = next_ptr(rp_ff); add_in = 1'b0;
               raddr_in = raddr_ff + 32'(WORD_BYTES);
               if (rrem_ff == '0) rv_in = RV_END;
               rrem_in = rrem_ff - 1'b1;
            end else be_in = '0;
         end
         default: begin be_in = '0; raddr_in = '0; rrem_in = '0; rv_in = RV_WAIT; end
      endcase

      unique case (sd_ff)
         SD_WAIT: begin
            if (req.start_pulse && !dir_ff) begin
               saddr_in = base_ff; saddr2_in = second_ff;
               srem_in = count_ff; srem2_in = second_count_ff; sd_in = SD_LOAD;
            end
         end
         SD_LOAD: if (req.tx_credit && rg_ff) begin
            saddr_in = saddr_ff + 32'(WORD_BYTES); sd_in = SD_COPY;
         end
         SD_COPY: begin
            if (req.tx_credit && rg_ff) begin
               if (srem_ff != '0) begin
                  txv_in = 1'b1; txw_in = req.mem_read_word;
                  saddr_in = saddr_ff + 32'(WORD_BYTES); srem_in = srem_ff - 1'b1;
               end else if (srem2_ff != '0) begin
                  srem_in = srem2_ff; srem2_in = '0; txv_in = 1'b0;
                  saddr_in = (saddr2_ff[30:28] == 3'b000) ? saddr2_ff
                                                        : saddr2_ff - 32'(WORD_BYTES);
                  sd_in = SD_LOAD;
               end else begin txv_in = 1'b0; sd_in = SD_END; end
            end else begin
               if (!req.tx_credit) begin
                  srem_in = srem_ff + 1'b1; saddr_in = saddr_ff - 32'(2 * WORD_BYTES);
               end else saddr_in = saddr_ff - 32'(WORD_BYTES);
               txv_in = 1'b0; sd_in = SD_LOAD;
            end
         end
         default: begin
            saddr_in = '0; saddr2_in = '0; srem_in = '0; srem2_in = '0; sd_in = SD_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0; second_ff <= '0; count_ff <= '0; second_count_ff <= '0; dir_ff <= 1'b0;
         arb_ff <= ARB_ROUND; pri_ff <= 1'b0; tim_ff <= '0; wg_ff <= 1'b0; rg_ff <= 1'b0;
         tag_ff <= '0; rp_ff <= '0; wp_ff <= '0; add_ff <= 1'b0; ph_ff <= PH_HEADER;
         left_ff <= '0; rv_ff <= RV_WAIT; raddr_ff <= '0; rrem_ff <= '0; hc_ff <= '0;
         sd_ff <= SD_WAIT; saddr_ff <= '0; saddr2_ff <= '0; srem_ff <= '0; srem2_ff <= '0;
         txv_ff <= 1'b0; txw_ff <= '0; wd_ff <= '0; be_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BASE_ADDR: begin base_ff <= csr_data; second_ff <= '0; end
               CSR_SECOND_ADDR: second_ff <= csr_data;
               CSR_WORD_COUNT: begin count_ff <= csr_data; second_count_ff <= '0; end
               CSR_SECOND_COUNT: second_count_ff <= csr_data;
               CSR_DIRECTION: dir_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (fire) begin
            arb_ff <= arb_in; pri_ff <= pri_in; tim_ff <= tim_in; wg_ff <= wg_in; rg_ff <= rg_in;
            tag_ff <= tag_in; rp_ff <= rp_in; wp_ff <= wp_in; add_ff <= add_in; ph_ff <= ph_in;
            left_ff <= left_in; rv_ff <= rv_in; raddr_ff <= raddr_in; rrem_ff <= rrem_in;
            hc_ff <= hc_in; sd_ff <= sd_in; saddr_ff <= saddr_in; saddr2_ff <= saddr2_in;
            srem_ff <= srem_in; srem2_ff <= srem2_in; txv_ff <= txv_in; txw_ff <= txw_in;
            wd_ff <= wd_in; be_ff <= be_in;
         end
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {7'b0, rv_in != RV_WAIT, sd_in != SD_WAIT, hc_in != '0, wd_in, be_in,
                         rg_in ? saddr_in : raddr_in, !(rp_in == wp_in && add_in),
                         txw_in, txv_in};
      end
   end

   // the memory port is granted to at most one dma
   assert property (@(posedge clock) disable iff (reset) !(wg_ff && rg_ff))
      else $error("both memory grants held");
   // a word write happens only under the write grant in the copy state
   assert property (@(posedge clock) disable iff (reset) fire && be_in == BE_FULL
                    |-> wg_ff && rv_ff == RV_COPY)
      else $error("memory write without grant");
   // a held result stays while not taken
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff && !rsp_tready
                    |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result lost while stalled");
endmodule
